// ----- design/mavw_pkg.sv -----
// Shared types and constants for the moving-average filter with warm-up.
// No dependencies.
package mavw_pkg;

  // Width and reset value of the window-length register
  localparam int unsigned LEN_W     = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // Operation codes carried by an input item
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- design/mavw_if.sv -----
// Valid/ready channel interfaces for the moving-average filter.
// Depends on nothing; widths follow SAMPLE_BITS.
interface mavw_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface mavw_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          window_full;

  modport source (output valid, output average, output window_full, input ready);
  modport sink   (input valid, input average, input window_full, output ready);
endinterface

// ----- design/mavw_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Uses mavw_pkg for its control and status structs.
module mavw_div #(
  parameter int unsigned DIVIDEND_W = 22,
  parameter int unsigned DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mavw_pkg::div_ctl_t    ctl_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output mavw_pkg::div_sts_t    sts_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;
  // dividend bits leave at the top while quotient bits enter at the bottom
  logic [DIVIDEND_W-1:0] quo_q;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/moving_average_warmup.sv -----
// Moving-average filter with warm-up: ring buffer, running sum, bit-serial divide.
// A push passes ST_UPD (sum update, divider start), ST_DIV (waits for the
//   one-bit-per-cycle divider) and ST_FIN (result registered once the output is free).
// One item at a time: no new item is taken until the previous push's result is registered.
// Reset (rst_ni, async, active low): window length 64, empty window, zero sum.
// Depends on mavw_pkg, mavw_if.sv and mavw_div.
module moving_average_warmup #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mavw_pkg::LEN_W-1:0]   cfg_wdata_i,
  mavw_in_if.sink                      in_i,
  mavw_out_if.source                   out_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  // sum of MAX_WINDOW signed samples
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;

  // Filter state
  logic [mavw_pkg::LEN_W-1:0] len_q;
  logic [ADDR_W-1:0]          wp_q;
  logic                       filled_q;
  logic signed [SUM_W-1:0]    sum_q;

  // Item in flight
  logic [ADDR_W-1:0]             pos_q;
  logic [SAMPLE_BITS-1:0]        sample_q;
  logic [SAMPLE_BITS-1:0]        rd_q;
  logic                          neg_q;

  // Output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic                   full_q;

  // Sample ring. Entries are only trusted once the window has filled since the
  // last clear: until then the slot being replaced has not been written and
  // counts as zero, so the ring itself needs no clearing pass.
  logic [SAMPLE_BITS-1:0] ring_q [MAX_WINDOW];

  logic [CNT_W-1:0]  len_act;
  logic              in_acc;
  logic [ADDR_W-1:0] rd_pos;

  logic [SAMPLE_BITS-1:0]  old_smp;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W-1:0]        next_cnt;
  logic                    wrap;
  logic [CNT_W-1:0]        divisor;

  mavw_pkg::div_ctl_t   div_ctl;
  mavw_pkg::div_sts_t   div_sts;
  logic [SUM_W-1:0]     quotient;
  logic [SAMPLE_BITS-1:0] q_lo;
  logic                 out_free;

  // Window length in force: zero acts as one, beyond the ring saturates
  always_comb begin
    if (len_q == '0) begin
      len_act = CNT_W'(1);
    end else if (int'(len_q) > int'(MAX_WINDOW)) begin
      len_act = CNT_W'(MAX_WINDOW);
    end else begin
      len_act = CNT_W'(len_q);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign rd_pos = (CNT_W'(wp_q) >= len_act) ? '0 : wp_q;

  // Running-sum update, done in ST_UPD once the ring read is back
  assign old_smp  = filled_q ? rd_q : '0;
  assign sum_new  = sum_q
                  - {{(SUM_W-SAMPLE_BITS){old_smp[SAMPLE_BITS-1]}}, old_smp}
                  + {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  assign next_cnt = CNT_W'(pos_q) + CNT_W'(1);
  assign wrap     = next_cnt >= len_act;
  // warm-up divides by the samples seen so far, afterwards by the full window
  assign divisor  = filled_q ? len_act : next_cnt;

  assign div_ctl.start = (state_q == ST_UPD);

  mavw_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (sum_mag),
    .divisor_i  (divisor),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  // Quotient always fits the sample range; apply the sign after truncation
  assign q_lo     = quotient[SAMPLE_BITS-1:0];
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= mavw_pkg::LEN_RESET;
      wp_q        <= '0;
      filled_q    <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_we_i) begin
            // new length restarts the window so the sum matches it
            len_q    <= cfg_wdata_i;
            wp_q     <= '0;
            filled_q <= 1'b0;
            sum_q    <= '0;
          end else if (in_acc) begin
            if (in_i.operation == mavw_pkg::OP_CLEAR) begin
              wp_q     <= '0;
              filled_q <= 1'b0;
              sum_q    <= '0;
            end else begin
              state_q <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          sum_q    <= sum_new;
          filled_q <= filled_q | wrap;
          wp_q     <= wrap ? '0 : ADDR_W'(next_cnt);
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_sts.done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Item payload and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q    <= rd_pos;
      sample_q <= in_i.sample;
    end
    if (state_q == ST_UPD) begin
      neg_q <= sum_new[SUM_W-1];
    end
    if (state_q == ST_FIN && out_free) begin
      avg_q  <= neg_q ? SAMPLE_BITS'(-q_lo) : q_lo;
      full_q <= filled_q;
    end
  end

  // Ring: registered read at item accept, write during the sum update
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= ring_q[rd_pos];
    end
    if (state_q == ST_UPD) begin
      ring_q[pos_q] <= sample_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.average     = avg_q;
  assign out_o.window_full = full_q;

  // The divider must be idle whenever a new item can be taken
  a_div_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_sts.busy)
    else $error("divider busy while input ready");

  // A divider completion only arrives while waiting for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV))
    else $error("divider done outside divide state");

  // Write position stays inside the active window
  a_wp_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(wp_q) < len_act)
    else $error("write position outside window");

  // The fill flag only drops through a clear or a length write
  a_filled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(filled_q) |-> $past(cfg_we_i || (in_acc && in_i.operation == mavw_pkg::OP_CLEAR)))
    else $error("fill flag dropped without a clear");

endmodule
